>>> src/sbfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbfd_pkg: shared definitions for the serial bus frame decoder
// Frame geometry, register codes and the records passed between the front
// end, the frame queue and the channel unpacker.
// ----------------------------------------------------------------------------
package sbfd_pkg;

   localparam int WIN_LEN      = 25;                    // bytes in one frame
   localparam int SEEN_W       = $clog2(WIN_LEN + 1);   // saturating byte count
   localparam int BYTE_W       = 8;
   localparam int NUM_CH       = 16;                    // proportional channels
   localparam int CH_IDX_W     = $clog2(NUM_CH);
   localparam int CHAN_BITS    = 11;
   localparam int STREAM_BITS  = NUM_CH * CHAN_BITS;    // packed channel bits
   localparam int STREAM_BYTES = STREAM_BITS / BYTE_W;  // bytes 1 .. 22
   localparam int FLAG_BYTE    = STREAM_BYTES + 1;      // byte carrying the flags
   localparam int FLAG_W       = 4;

   localparam int FQ_DEPTH     = 2;                     // decoded frames in flight
   localparam int FQ_PTR_W     = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
   localparam int FQ_CNT_W     = $clog2(FQ_DEPTH + 1);

   localparam int CSR_IDX_W    = 1;
   localparam logic [BYTE_W-1:0] START_MARKER_RESET = 8'h0F;
   localparam logic [BYTE_W-1:0] END_MARKER_RESET   = 8'h00;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_MARKER = 1'b0,
      CSR_END_MARKER   = 1'b1
   } csr_index_type;

   // Flag bit positions within byte 23.
   localparam int FLAG_DIGITAL_FIRST  = 0;
   localparam int FLAG_DIGITAL_SECOND = 1;
   localparam int FLAG_FRAME_LOST     = 2;
   localparam int FLAG_FAILSAFE       = 3;

   typedef struct packed {
      logic [STREAM_BITS-1:0] stream;  // channel 0 in the low bits
      logic [FLAG_W-1:0]      flags;
   } frame_type;

   typedef struct packed {
      logic [CH_IDX_W-1:0]  channel_index;
      logic [CHAN_BITS-1:0] channel_value;
      logic [FLAG_W-1:0]    flags;
      logic                 last_of_frame;
   } result_type;

endpackage

>>> src/sbfd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbfd_front: byte window and frame match
// Shifts received bytes into a 25-byte window, keeps the marker registers and
// hands every matching frame to the frame queue in the same cycle.
// ----------------------------------------------------------------------------
module sbfd_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             byte_accept_i,
   input  logic [sbfd_pkg::BYTE_W-1:0]      rx_byte_i,
   input  logic                             csr_wr_en_i,
   input  logic [sbfd_pkg::CSR_IDX_W-1:0]   csr_index_i,
   input  logic [sbfd_pkg::BYTE_W-1:0]      csr_data_i,
   output logic                             frame_push_o,
   output sbfd_pkg::frame_type              frame_o
);

   logic [sbfd_pkg::BYTE_W-1:0] window_ff [sbfd_pkg::WIN_LEN];
   logic [sbfd_pkg::SEEN_W-1:0] seen_ff;
   logic [sbfd_pkg::SEEN_W-1:0] seen_in;
   logic [sbfd_pkg::BYTE_W-1:0] start_marker_ff;
   logic [sbfd_pkg::BYTE_W-1:0] end_marker_ff;
   logic                        window_full;

   // The window holds no reset; the byte count guards every read of it.
   always_ff @(posedge clock) begin
      if (byte_accept_i) begin
         for (int i = 0; i < sbfd_pkg::WIN_LEN - 1; i++) begin
            window_ff[i] <= window_ff[i+1];
         end
         window_ff[sbfd_pkg::WIN_LEN-1] <= rx_byte_i;
      end
   end

   always_comb begin
      seen_in = seen_ff;
      if (byte_accept_i && (seen_ff != sbfd_pkg::SEEN_W'(sbfd_pkg::WIN_LEN))) begin
         seen_in = seen_ff + sbfd_pkg::SEEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff         <= '0;
         start_marker_ff <= sbfd_pkg::START_MARKER_RESET;
         end_marker_ff   <= sbfd_pkg::END_MARKER_RESET;
      end else begin
         seen_ff <= seen_in;
         if (csr_wr_en_i) begin
            unique case (csr_index_i)
               sbfd_pkg::CSR_START_MARKER: start_marker_ff <= csr_data_i;
               sbfd_pkg::CSR_END_MARKER:   end_marker_ff   <= csr_data_i;
               default: ;
            endcase
         end
      end
   end

   // The match looks at the window as it will be after this byte shifts in:
   // the new oldest byte is the current entry 1.
   assign window_full  = (seen_ff >= sbfd_pkg::SEEN_W'(sbfd_pkg::WIN_LEN - 1));
   assign frame_push_o = byte_accept_i && window_full &&
                         (window_ff[1] == start_marker_ff) &&
                         (rx_byte_i == end_marker_ff);

   always_comb begin
      for (int i = 0; i < sbfd_pkg::STREAM_BYTES; i++) begin
         frame_o.stream[i*sbfd_pkg::BYTE_W +: sbfd_pkg::BYTE_W] = window_ff[i+2];
      end
      frame_o.flags = window_ff[sbfd_pkg::FLAG_BYTE+1][sbfd_pkg::FLAG_W-1:0];
   end

endmodule

>>> src/sbfd_frame_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbfd_frame_queue: queue of decoded frames
// Holds matched frames between the front end and the channel unpacker.
// ----------------------------------------------------------------------------
module sbfd_frame_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_i,
   input  sbfd_pkg::frame_type push_frame_i,
   output logic                full_o,
   input  logic                pop_i,
   output logic                valid_o,
   output sbfd_pkg::frame_type head_o
);

   sbfd_pkg::frame_type              entry_ff [sbfd_pkg::FQ_DEPTH];
   logic [sbfd_pkg::FQ_PTR_W-1:0]    wr_ptr_ff;
   logic [sbfd_pkg::FQ_PTR_W-1:0]    rd_ptr_ff;
   logic [sbfd_pkg::FQ_CNT_W-1:0]    count_ff;

   function automatic logic [sbfd_pkg::FQ_PTR_W-1:0] next_ptr(
      input logic [sbfd_pkg::FQ_PTR_W-1:0] ptr);
      if (ptr == sbfd_pkg::FQ_PTR_W'(sbfd_pkg::FQ_DEPTH - 1)) begin
         return '0;
      end
      return ptr + sbfd_pkg::FQ_PTR_W'(1);
   endfunction

   assign full_o  = (count_ff == sbfd_pkg::FQ_CNT_W'(sbfd_pkg::FQ_DEPTH));
   assign valid_o = (count_ff != '0);
   assign head_o  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push_i) begin
         entry_ff[wr_ptr_ff] <= push_frame_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_i) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (pop_i) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (push_i && !pop_i) begin
            count_ff <= count_ff + sbfd_pkg::FQ_CNT_W'(1);
         end else if (pop_i && !push_i) begin
            count_ff <= count_ff - sbfd_pkg::FQ_CNT_W'(1);
         end
      end
   end

   // Occupancy never passes the depth.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= sbfd_pkg::FQ_CNT_W'(sbfd_pkg::FQ_DEPTH))
      else $error("frame queue count above depth");

   // The unpacker only takes a frame that is there.
   assert property (@(posedge clock) disable iff (reset)
      pop_i |-> valid_o)
      else $error("frame queue popped while empty");

endmodule

>>> src/sbfd_unpack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbfd_unpack: channel unpacker
// Takes one frame at a time from the queue and emits its sixteen channels,
// one per cycle while the output is not stalled, through an output register.
// ----------------------------------------------------------------------------
module sbfd_unpack (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 frame_valid_i,
   input  sbfd_pkg::frame_type  frame_i,
   output logic                 frame_pop_o,
   output logic                 result_valid_o,
   output sbfd_pkg::result_type result_o,
   input  logic                 result_pop_i
);

   logic                              busy_ff;
   logic                              busy_in;
   logic [sbfd_pkg::CH_IDX_W-1:0]     chan_ff;
   logic [sbfd_pkg::CH_IDX_W-1:0]     chan_in;
   logic [sbfd_pkg::STREAM_BITS-1:0]  stream_ff;
   logic [sbfd_pkg::STREAM_BITS-1:0]  stream_in;
   logic [sbfd_pkg::FLAG_W-1:0]       flags_ff;
   logic                              out_valid_ff;
   logic                              out_valid_in;
   sbfd_pkg::result_type              out_ff;
   logic                              advance;
   logic                              emit;
   logic                              last_chan;
   logic                              load;

   assign advance   = !out_valid_ff || result_pop_i;
   assign emit      = advance && busy_ff;
   assign last_chan = (chan_ff == sbfd_pkg::CH_IDX_W'(sbfd_pkg::NUM_CH - 1));
   // A new frame follows the last channel of the previous one without a gap.
   assign load      = frame_valid_i && (!busy_ff || (emit && last_chan));

   always_comb begin
      busy_in      = busy_ff;
      chan_in      = chan_ff;
      stream_in    = stream_ff;
      out_valid_in = advance ? busy_ff : out_valid_ff;
      if (load) begin
         busy_in   = 1'b1;
         chan_in   = '0;
         stream_in = frame_i.stream;
      end else if (emit) begin
         busy_in   = !last_chan;
         chan_in   = chan_ff + sbfd_pkg::CH_IDX_W'(1);
         stream_in = stream_ff >> sbfd_pkg::CHAN_BITS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         chan_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         chan_ff      <= chan_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stream_ff <= stream_in;
      if (load) begin
         flags_ff <= frame_i.flags;
      end
      if (emit) begin
         out_ff.channel_index <= chan_ff;
         out_ff.channel_value <= stream_ff[sbfd_pkg::CHAN_BITS-1:0];
         out_ff.flags         <= flags_ff;
         out_ff.last_of_frame <= last_chan;
      end
   end

   assign frame_pop_o    = load;
   assign result_valid_o = out_valid_ff;
   assign result_o       = out_ff;

   // The end-of-frame mark only ever rides on the last channel.
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.last_of_frame) |->
         (out_ff.channel_index == sbfd_pkg::CH_IDX_W'(sbfd_pkg::NUM_CH - 1)))
      else $error("last_of_frame on a channel other than the last");

   // A stalled output freezes the channel walk.
   assert property (@(posedge clock) disable iff (reset)
      (busy_ff && out_valid_ff && !result_pop_i) |=> ($stable(chan_ff) && busy_ff))
      else $error("channel counter moved while output stalled");

endmodule

>>> src/sbus_frame_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbus_frame_decoder_core: serial bus frame decoder, 16 channels of 11 bits
// Slides received bytes through a 25-byte window, recognizes a frame by its
// start and end markers and unpacks sixteen channels with the frame flags.
// ----------------------------------------------------------------------------
//
//   Channel  Ports                          Direction  Transaction
//   -------  -----------------------------  ---------  ---------------------
//   req      req_push, req_full, req_*      in         push && !full, 1 byte
//   rsp      rsp_empty, rsp_pop, rsp_*      out        pop && !empty, 1 chan
//   csr      csr_wr_en, csr_index, csr_data in         wr_en, 1 marker write
//
// One byte is taken per cycle while req_full is low. A byte that completes a
// matching frame puts the frame into a two-entry frame queue; the unpacker
// walks a frame one channel per cycle while rsp is not stalled, so a frame
// costs 16 result transactions. req_full rises only while the frame queue
// holds two frames. A stalled rsp side holds the unpacker, never the byte
// window, until that queue fills. reset is synchronous; it clears the byte
// count and restores the markers.
//
// The front end compares the window as it will stand after the incoming
// byte, so the match and the frame capture happen in the cycle the byte is
// accepted. Bytes 1 to 22 form a 176-bit stream, least significant bit of
// byte 1 first; channel k is stream bits 11k to 11k+10. The unpacker shifts
// that stream right by eleven bits per result. The window keeps sliding after
// a match, so any later window that matches is decoded again.
// ----------------------------------------------------------------------------
module sbus_frame_decoder_core (
   input  logic                             clock,
   input  logic                             reset,
   // Byte input.
   input  logic                             req_push,
   output logic                             req_full,
   input  logic [sbfd_pkg::BYTE_W-1:0]      req_rx_byte,
   // Channel results.
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic [sbfd_pkg::CH_IDX_W-1:0]    rsp_channel_index,
   output logic [sbfd_pkg::CHAN_BITS-1:0]   rsp_channel_value,
   output logic                             rsp_frame_lost,
   output logic                             rsp_failsafe,
   output logic                             rsp_digital_first,
   output logic                             rsp_digital_second,
   output logic                             rsp_last_of_frame,
   // Marker registers.
   input  logic                             csr_wr_en,
   input  logic [sbfd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sbfd_pkg::BYTE_W-1:0]      csr_data
);

   logic                 byte_accept;
   logic                 frame_push;
   sbfd_pkg::frame_type  frame_in;
   logic                 fq_full;
   logic                 fq_valid;
   logic                 fq_pop;
   sbfd_pkg::frame_type  fq_head;
   logic                 result_valid;
   sbfd_pkg::result_type result;

   // Every byte may complete a frame, so bytes wait only on queue space.
   assign req_full    = fq_full;
   assign byte_accept = req_push && !fq_full;

   sbfd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .byte_accept_i (byte_accept),
      .rx_byte_i     (req_rx_byte),
      .csr_wr_en_i   (csr_wr_en),
      .csr_index_i   (csr_index),
      .csr_data_i    (csr_data),
      .frame_push_o  (frame_push),
      .frame_o       (frame_in)
   );

   sbfd_frame_queue u_frame_queue (
      .clock        (clock),
      .reset        (reset),
      .push_i       (frame_push),
      .push_frame_i (frame_in),
      .full_o       (fq_full),
      .pop_i        (fq_pop),
      .valid_o      (fq_valid),
      .head_o       (fq_head)
   );

   sbfd_unpack u_unpack (
      .clock          (clock),
      .reset          (reset),
      .frame_valid_i  (fq_valid),
      .frame_i        (fq_head),
      .frame_pop_o    (fq_pop),
      .result_valid_o (result_valid),
      .result_o       (result),
      .result_pop_i   (rsp_pop && result_valid)
   );

   assign rsp_empty          = !result_valid;
   assign rsp_channel_index  = result.channel_index;
   assign rsp_channel_value  = result.channel_value;
   assign rsp_frame_lost     = result.flags[sbfd_pkg::FLAG_FRAME_LOST];
   assign rsp_failsafe       = result.flags[sbfd_pkg::FLAG_FAILSAFE];
   assign rsp_digital_first  = result.flags[sbfd_pkg::FLAG_DIGITAL_FIRST];
   assign rsp_digital_second = result.flags[sbfd_pkg::FLAG_DIGITAL_SECOND];
   assign rsp_last_of_frame  = result.last_of_frame;

endmodule
